### hw/rtl/sdspi_pkg.sv
package sdspi_pkg;

	localparam int LEN_W = 10;
	localparam int CNT_W = 10;

	localparam logic [7:0] BYTE_IDLE  = 8'hff;
	localparam logic [7:0] BYTE_TOKEN = 8'hfe;
	localparam logic [7:0] BYTE_ZERO  = 8'h00;
	localparam logic [7:0] R1_IDLE    = 8'h01;
	localparam logic [7:0] CRC_DUMMY  = 8'h01;
	localparam logic [7:0] CRC_CMD0   = 8'h94 | 8'h01;
	localparam logic [1:0] CMD_PREFIX = 2'b01;
	localparam logic [7:0] RESP_HI_MASK = 8'he0;
	localparam logic [7:0] RESP_LO_MASK = 8'h1f;
	localparam logic [4:0] RESP_ACCEPTED = 5'd5;
	localparam logic [4:0] RESP_CRC_ERR  = 5'd11;
	localparam logic [4:0] RESP_WR_ERR   = 5'd13;
	localparam logic [2:0] FRAME_LEN  = 3'd6;
	localparam logic [CNT_W-1:0] WR_CRC_LEN = CNT_W'(2);

	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_RECEIVE = 1'b1;

	localparam logic [1:0] KIND_NODATA = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_WRITE  = 2'd2;
	localparam logic [1:0] KIND_INIT   = 2'd3;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_CRC_ERR   = 3'd1;
	localparam logic [2:0] STAT_WR_ERR    = 3'd2;
	localparam logic [2:0] STAT_UNKNOWN   = 3'd3;
	localparam logic [2:0] STAT_ERR_TOKEN = 3'd4;
	localparam logic [2:0] STAT_BUSY      = 3'd5;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_DUMMY    = 4'd1,
		PH_NOTBUSY  = 4'd2,
		PH_FRAME    = 4'd3,
		PH_R1       = 4'd4,
		PH_RD_TOKEN = 4'd5,
		PH_RD_DATA  = 4'd6,
		PH_RD_CRC   = 4'd7,
		PH_ND_DATA  = 4'd8,
		PH_WR_TOKEN = 4'd9,
		PH_WR_DATA  = 4'd10,
		PH_WR_CRC   = 4'd11,
		PH_WR_RESP  = 4'd12,
		PH_WR_BUSY  = 4'd13
	} sdspi_phase_t;

	typedef struct packed {
		sdspi_phase_t     phase;
		logic [CNT_W-1:0] byte_count;
		logic [5:0]       saved_command;
		logic [31:0]      saved_argument;
		logic [1:0]       saved_kind;
		logic [LEN_W-1:0] saved_length;
		logic             init_stage;
		logic [7:0]       last_response;
	} sdspi_state_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       select;
		logic [7:0] rd_byte;
		logic       rd_valid;
		logic       want_write_byte;
		logic       done_res;
		logic [2:0] status;
		logic [7:0] card_flags;
	} sdspi_result_t;

	// Command frame byte at position idx (0 = start byte, 5 = crc)
	function automatic logic [7:0] frame_byte(input logic [1:0] kind, input logic init_stage,
			input logic [5:0] cmd, input logic [31:0] arg, input logic [2:0] idx);
		logic [5:0]  c;
		logic [31:0] a;
		logic [7:0]  b;
		c = (kind == KIND_INIT) ? {5'b0, init_stage} : cmd;
		a = (kind == KIND_INIT) ? 32'b0 : arg;
		unique case (idx)
			3'd0: b = {CMD_PREFIX, c};
			3'd1: b = a[31:24];
			3'd2: b = a[23:16];
			3'd3: b = a[15:8];
			3'd4: b = a[7:0];
			default: b = ((kind == KIND_INIT) && !init_stage) ? CRC_CMD0 : CRC_DUMMY;
		endcase
		return b;
	endfunction

	// Decode the data response token of a block write
	function automatic logic [2:0] write_status(input logic [7:0] r);
		logic [2:0] s;
		logic [4:0] lo;
		lo = r[4:0] & RESP_LO_MASK[4:0];
		if ((r & RESP_HI_MASK) == 8'h00) begin
			s = STAT_ERR_TOKEN;
		end else if (lo == RESP_ACCEPTED) begin
			s = STAT_OK;
		end else if (lo == RESP_CRC_ERR) begin
			s = STAT_CRC_ERR;
		end else if (lo == RESP_WR_ERR) begin
			s = STAT_WR_ERR;
		end else begin
			s = STAT_UNKNOWN;
		end
		return s;
	endfunction

endpackage

### hw/rtl/sdspi_step.sv
module sdspi_step #(
	parameter int MAX_BLOCK   = 512,
	parameter int DUMMY_BYTES = 10
) (
	input  sdspi_pkg::sdspi_state_t          cur,
	input  logic                             action,
	input  logic [1:0]                       kind,
	input  logic [5:0]                       command,
	input  logic [31:0]                      argument,
	input  logic [sdspi_pkg::LEN_W-1:0]      length,
	input  logic [7:0]                       rx_byte,
	input  logic [7:0]                       wr_byte,
	output sdspi_pkg::sdspi_state_t          nxt,
	output sdspi_pkg::sdspi_result_t         res
);

	localparam int LW = sdspi_pkg::LEN_W;
	localparam int CW = sdspi_pkg::CNT_W;

	logic [LW-1:0] len_sat;
	logic [CW-1:0] cnt_inc;
	logic          len_zero;

	// Clamp the requested length to the largest block
	assign len_sat  = ({{(32-LW){1'b0}}, length} > 32'(MAX_BLOCK)) ? LW'(MAX_BLOCK) : length;
	assign cnt_inc  = cur.byte_count + CW'(1);
	assign len_zero = (cur.saved_length == '0);

	// Next state and the one result for this item
	always_comb begin
		nxt = cur;
		res = '0;
		if (action == sdspi_pkg::ACT_START) begin
			if (cur.phase != sdspi_pkg::PH_IDLE) begin
				res.status = sdspi_pkg::STAT_BUSY;
			end else begin
				nxt.saved_kind     = kind;
				nxt.saved_command  = command;
				nxt.saved_argument = argument;
				nxt.saved_length   = len_sat;
				nxt.init_stage     = 1'b0;
				res.tx_valid = 1'b1;
				res.tx_byte  = sdspi_pkg::BYTE_IDLE;
				if (kind == sdspi_pkg::KIND_INIT) begin
					nxt.phase      = sdspi_pkg::PH_DUMMY;
					nxt.byte_count = CW'(1);
				end else begin
					nxt.phase  = sdspi_pkg::PH_NOTBUSY;
					res.select = 1'b1;
				end
			end
		end else begin
			unique case (cur.phase)
				sdspi_pkg::PH_IDLE: begin
				end
				sdspi_pkg::PH_DUMMY: begin
					res.tx_valid = 1'b1;
					res.tx_byte  = sdspi_pkg::BYTE_IDLE;
					if (cur.byte_count < CW'(DUMMY_BYTES)) begin
						nxt.byte_count = cnt_inc;
					end else begin
						nxt.phase  = sdspi_pkg::PH_NOTBUSY;
						res.select = 1'b1;
					end
				end
				sdspi_pkg::PH_NOTBUSY: begin
					res.tx_valid = 1'b1;
					res.select   = 1'b1;
					if (rx_byte == sdspi_pkg::BYTE_IDLE) begin
						nxt.phase      = sdspi_pkg::PH_FRAME;
						nxt.byte_count = CW'(1);
						res.tx_byte    = sdspi_pkg::frame_byte(cur.saved_kind, cur.init_stage,
							cur.saved_command, cur.saved_argument, 3'd0);
					end else begin
						res.tx_byte = sdspi_pkg::BYTE_IDLE;
					end
				end
				sdspi_pkg::PH_FRAME: begin
					res.tx_valid = 1'b1;
					res.select   = 1'b1;
					if (cur.byte_count < CW'(sdspi_pkg::FRAME_LEN)) begin
						res.tx_byte    = sdspi_pkg::frame_byte(cur.saved_kind, cur.init_stage,
							cur.saved_command, cur.saved_argument, cur.byte_count[2:0]);
						nxt.byte_count = cnt_inc;
					end else begin
						nxt.phase   = sdspi_pkg::PH_R1;
						res.tx_byte = sdspi_pkg::BYTE_IDLE;
					end
				end
				sdspi_pkg::PH_R1: begin
					if (rx_byte == sdspi_pkg::BYTE_IDLE) begin
						res.tx_valid = 1'b1;
						res.select   = 1'b1;
						res.tx_byte  = sdspi_pkg::BYTE_IDLE;
					end else begin
						nxt.last_response = rx_byte;
						if (cur.saved_kind == sdspi_pkg::KIND_INIT && !cur.init_stage) begin
							res.tx_valid = 1'b1;
							res.tx_byte  = sdspi_pkg::BYTE_IDLE;
							if (rx_byte == sdspi_pkg::R1_IDLE) begin
								nxt.init_stage = 1'b1;
								nxt.phase      = sdspi_pkg::PH_NOTBUSY;
								res.select     = 1'b1;
							end else begin
								nxt.phase      = sdspi_pkg::PH_DUMMY;
								nxt.byte_count = CW'(1);
							end
						end else if (rx_byte != 8'h00) begin
							nxt.phase    = sdspi_pkg::PH_NOTBUSY;
							res.tx_valid = 1'b1;
							res.select   = 1'b1;
							res.tx_byte  = sdspi_pkg::BYTE_IDLE;
						end else begin
							// R1 clean: move to the data part of the transfer, or finish if there is none
							nxt.byte_count = '0;
							unique case (cur.saved_kind)
								sdspi_pkg::KIND_NODATA: begin
									if (len_zero) begin
										nxt.phase    = sdspi_pkg::PH_IDLE;
										res.done_res = 1'b1;
									end else begin
										nxt.phase    = sdspi_pkg::PH_ND_DATA;
										res.tx_valid = 1'b1;
										res.select   = 1'b1;
										res.tx_byte  = sdspi_pkg::BYTE_IDLE;
									end
								end
								sdspi_pkg::KIND_READ: begin
									nxt.phase    = sdspi_pkg::PH_RD_TOKEN;
									res.tx_valid = 1'b1;
									res.select   = 1'b1;
									res.tx_byte  = sdspi_pkg::BYTE_IDLE;
								end
								sdspi_pkg::KIND_WRITE: begin
									nxt.phase    = sdspi_pkg::PH_WR_TOKEN;
									res.tx_valid = 1'b1;
									res.select   = 1'b1;
									res.tx_byte  = sdspi_pkg::BYTE_IDLE;
								end
								default: begin
									nxt.init_stage = 1'b0;
									nxt.phase      = sdspi_pkg::PH_IDLE;
									res.done_res   = 1'b1;
								end
							endcase
						end
					end
				end
				sdspi_pkg::PH_ND_DATA, sdspi_pkg::PH_RD_DATA: begin
					res.rd_byte    = rx_byte;
					res.rd_valid   = 1'b1;
					nxt.byte_count = cnt_inc;
					if (cnt_inc >= cur.saved_length && cur.phase == sdspi_pkg::PH_ND_DATA) begin
						nxt.phase    = sdspi_pkg::PH_IDLE;
						res.done_res = 1'b1;
					end else begin
						if (cnt_inc >= cur.saved_length) begin
							nxt.phase      = sdspi_pkg::PH_RD_CRC;
							nxt.byte_count = '0;
						end
						res.tx_valid = 1'b1;
						res.select   = 1'b1;
						res.tx_byte  = sdspi_pkg::BYTE_IDLE;
					end
				end
				sdspi_pkg::PH_RD_TOKEN: begin
					if (rx_byte == sdspi_pkg::BYTE_TOKEN) begin
						nxt.byte_count = '0;
						nxt.phase = len_zero ? sdspi_pkg::PH_RD_CRC : sdspi_pkg::PH_RD_DATA;
					end
					res.tx_valid = 1'b1;
					res.select   = 1'b1;
					res.tx_byte  = sdspi_pkg::BYTE_IDLE;
				end
				sdspi_pkg::PH_RD_CRC: begin
					if (cur.byte_count == '0) begin
						nxt.byte_count = CW'(1);
						res.tx_valid   = 1'b1;
						res.select     = 1'b1;
						res.tx_byte    = sdspi_pkg::BYTE_IDLE;
					end else begin
						nxt.phase    = sdspi_pkg::PH_IDLE;
						res.done_res = 1'b1;
					end
				end
				sdspi_pkg::PH_WR_TOKEN: begin
					res.tx_valid   = 1'b1;
					res.select     = 1'b1;
					res.tx_byte    = sdspi_pkg::BYTE_TOKEN;
					nxt.byte_count = '0;
					if (!len_zero) begin
						nxt.phase           = sdspi_pkg::PH_WR_DATA;
						res.want_write_byte = 1'b1;
					end else begin
						nxt.phase = sdspi_pkg::PH_WR_CRC;
					end
				end
				sdspi_pkg::PH_WR_DATA: begin
					res.tx_valid   = 1'b1;
					res.select     = 1'b1;
					res.tx_byte    = wr_byte;
					nxt.byte_count = cnt_inc;
					if (cnt_inc >= cur.saved_length) begin
						nxt.phase      = sdspi_pkg::PH_WR_CRC;
						nxt.byte_count = '0;
					end else begin
						res.want_write_byte = 1'b1;
					end
				end
				sdspi_pkg::PH_WR_CRC: begin
					res.tx_valid = 1'b1;
					res.select   = 1'b1;
					if (cur.byte_count < sdspi_pkg::WR_CRC_LEN) begin
						nxt.byte_count = cnt_inc;
						res.tx_byte    = sdspi_pkg::BYTE_ZERO;
					end else begin
						nxt.phase   = sdspi_pkg::PH_WR_RESP;
						res.tx_byte = sdspi_pkg::BYTE_IDLE;
					end
				end
				sdspi_pkg::PH_WR_RESP: begin
					if (rx_byte != sdspi_pkg::BYTE_IDLE) begin
						nxt.last_response = rx_byte;
						nxt.phase         = sdspi_pkg::PH_WR_BUSY;
					end
					res.tx_valid = 1'b1;
					res.select   = 1'b1;
					res.tx_byte  = sdspi_pkg::BYTE_IDLE;
				end
				sdspi_pkg::PH_WR_BUSY: begin
					if (rx_byte == sdspi_pkg::BYTE_IDLE) begin
						nxt.phase    = sdspi_pkg::PH_IDLE;
						res.done_res = 1'b1;
						res.status   = sdspi_pkg::write_status(cur.last_response);
					end else begin
						res.tx_valid = 1'b1;
						res.select   = 1'b1;
						res.tx_byte  = sdspi_pkg::BYTE_IDLE;
					end
				end
				default: begin
					nxt.phase = sdspi_pkg::PH_IDLE;
				end
			endcase
		end
		res.card_flags = nxt.last_response;
	end

endmodule

### hw/rtl/sd_spi_command_sequencer_top.sv
// The result of an accepted item is loaded into the output register in the cycle after it is accepted.
// Throughput: one item per cycle; the sequencer state and the output register
// update on the same edge, and a new item is taken while a result is pending
// as long as that result is taken in the same cycle.
// Reset (arst_n low, asynchronous): sequencer idle, all saved fields and the
// last card response cleared, no result pending.
module sd_spi_command_sequencer_top #(
	parameter int MAX_BLOCK   = 512,
	parameter int DUMMY_BYTES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        action,
	input  logic [1:0]  kind,
	input  logic [5:0]  command,
	input  logic [31:0] argument,
	input  logic [9:0]  length,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  wr_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [7:0]  tx_byte,
	output logic        tx_valid,
	output logic        select,
	output logic [7:0]  rd_byte,
	output logic        rd_valid,
	output logic        want_write_byte,
	output logic        done_res,
	output logic [2:0]  status,
	output logic [7:0]  card_flags
);

	sdspi_pkg::sdspi_state_t  state_q;
	sdspi_pkg::sdspi_state_t  state_nxt;
	sdspi_pkg::sdspi_result_t res_nxt;
	sdspi_pkg::sdspi_result_t res_q;
	logic                     res_valid_q;
	logic                     accept;

	// Take an item whenever the output register is empty or being drained
	assign req_ready = !res_valid_q || res_ready;
	assign accept    = req_valid && req_ready;

	sdspi_step #(
		.MAX_BLOCK   (MAX_BLOCK),
		.DUMMY_BYTES (DUMMY_BYTES)
	) u_step (
		.cur      (state_q),
		.action   (action),
		.kind     (kind),
		.command  (command),
		.argument (argument),
		.length   (length),
		.rx_byte  (rx_byte),
		.wr_byte  (wr_byte),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	// Hold the sequencer state; advance it on each accepted item
	// (all-zero state is the idle phase)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Load the result payload with the item
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid       = res_valid_q;
	assign tx_byte         = res_q.tx_byte;
	assign tx_valid        = res_q.tx_valid;
	assign select          = res_q.select;
	assign rd_byte         = res_q.rd_byte;
	assign rd_valid        = res_q.rd_valid;
	assign want_write_byte = res_q.want_write_byte;
	assign done_res        = res_q.done_res;
	assign status          = res_q.status;
	assign card_flags      = res_q.card_flags;

`ifndef SYNTHESIS
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> res_valid)
		else $error("accepted item produced no result");

	a_done_no_exchange: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !tx_valid && !want_write_byte)
		else $error("finished transfer still asks for an exchange");

	a_busy_refusal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == sdspi_pkg::STAT_BUSY |-> !tx_valid && !done_res && !rd_valid)
		else $error("refused request produced activity");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && res_nxt.done_res |=> state_q.phase == sdspi_pkg::PH_IDLE)
		else $error("sequencer not idle after finishing");
`endif

endmodule
